### sv/assert_macros.svh
// assertion macros for the evaluator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property p must hold every cycle out of reset
`define ASSERT_ALWAYS(label, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);
// when a holds, c must hold in the next cycle
`define ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### sv/pbe_pkg.sv
// shared constants and types for the postfix bytecode evaluator
package pbe_pkg;
  localparam int StackDepth = 32;
  localparam int SpW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_MANY     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // classified command kinds
  localparam logic [1:0] K_PUSH = 2'd0;
  localparam logic [1:0] K_OP   = 2'd1;
  localparam logic [1:0] K_END  = 2'd2;

  localparam logic [5:0] OP_LOR  = 6'd6;
  localparam logic [5:0] OP_LAND = 6'd7;
  localparam logic [5:0] OP_LE   = 6'd8;
  localparam logic [5:0] OP_LT   = 6'd9;
  localparam logic [5:0] OP_GE   = 6'd10;
  localparam logic [5:0] OP_GT   = 6'd11;
  localparam logic [5:0] OP_EQ   = 6'd12;
  localparam logic [5:0] OP_NE   = 6'd13;
  localparam logic [5:0] OP_XOR  = 6'd14;
  localparam logic [5:0] OP_OR   = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_ADD  = 6'd17;
  localparam logic [5:0] OP_SUB  = 6'd18;
  localparam logic [5:0] OP_MUL  = 6'd19;
  localparam logic [5:0] OP_DIV  = 6'd20;
  localparam logic [5:0] OP_MOD  = 6'd21;
  localparam logic [5:0] OP_NEG  = 6'd22;
  localparam logic [5:0] OP_LNOT = 6'd23;
  localparam logic [5:0] OP_NOT  = 6'd24;
  localparam logic [5:0] OP_BAD  = 6'd63;

  // command passed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  op;
    logic [31:0] data;
  } cmd_t;

  localparam int QDepth = 4;
  localparam int QPw = $clog2(QDepth);
endpackage

### sv/postfix_bytecode_evaluator.sv
// top level of the postfix bytecode evaluator
// Bytes are taken one per cycle into a four-entry command queue while it has room;
// literal bytes are pushed from the idle state, operators pass through the stack read
// and execute states in the back end, divide and modulo then wait on the bit-serial
// divider, and the end opcode passes through stack read after the wait for the previous
// result to be taken. One result per expression is held in an output register.
module postfix_bytecode_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [2:0]  out_status
);
  import pbe_pkg::*;
  `include "assert_macros.svh"

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  pbe_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_code_byte(in_code_byte), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );
  pbe_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );
  pbe_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  `ASSERT_ALWAYS(a_status_range, !out_valid || out_status <= ST_OVERFLOW, "bad status")
  `ASSERT_ALWAYS(a_err_zero, !out_valid || out_status == ST_OK || out_value == 32'd0, "value not zero")
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "result dropped")
endmodule

### sv/pbe_front.sv
// front end: literal assembly and opcode classification
module pbe_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_code_byte,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output pbe_pkg::cmd_t  cmd
);
  import pbe_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [31:0] part;
  logic        is_cont, is_close, take;

  assign is_cont  = in_code_byte[7] & in_code_byte[6];
  assign is_close = !is_cont && (in_code_byte[7] || sh_r != 6'd0);
  assign in_ready = cmd_ready;
  assign take     = in_valid && in_ready;
  assign part     = (sh_r < 6'd32) ? ({25'd0, in_code_byte[6:0]} << sh_r[4:0]) : 32'd0;

  // classify the byte into a command
  always_comb begin
    cmd.kind = K_OP;
    cmd.op   = OP_BAD;
    cmd.data = acc_r + part;
    if (is_close) begin
      cmd.kind = K_PUSH;
    end else if (in_code_byte == 8'd0) begin
      cmd.kind = K_END;
    end else if (!in_code_byte[7] && !in_code_byte[6] &&
                 in_code_byte[5:0] >= OP_LOR && in_code_byte[5:0] <= OP_NOT) begin
      cmd.op = in_code_byte[5:0];
    end
  end
  assign cmd_valid = in_valid && !is_cont;

  // literal accumulator
  always_comb begin
    acc_nxt = acc_r;
    sh_nxt  = sh_r;
    if (is_cont) begin
      acc_nxt = acc_r + part;
      if (sh_r < 6'd32) sh_nxt = sh_r + 6'd6;
    end else begin
      acc_nxt = 32'd0;
      sh_nxt  = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
      sh_r  <= 6'd0;
    end else if (take) begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
    end
  end
endmodule

### sv/pbe_queue.sv
// small fifo decoupling front and back
module pbe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pbe_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pbe_pkg::cmd_t rd_data
);
  import pbe_pkg::*;

  cmd_t slot_r [QDepth];
  logic [QPw-1:0] wp_r, rp_r;
  logic [QPw:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != QPw'(0) + (QPw+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr) slot_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + QPw'(1);
      if (rd) rp_r <= rp_r + QPw'(1);
      cnt_r <= cnt_r + (QPw+1)'(wr) - (QPw+1)'(rd);
    end
  end
endmodule

### sv/pbe_div.sv
// iterative signed 32-bit divider, one quotient bit per cycle
module pbe_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  import pbe_pkg::*;

  logic [31:0] q_r, d_r;
  logic [32:0] r_r;
  logic [5:0]  n_r;
  logic        busy_r, nq_r, nr_r;
  logic [32:0] trial;
  logic [31:0] a_mag, b_mag, b_eff;

  assign b_eff = (divisor == 32'd0) ? 32'd1 : divisor;
  assign a_mag = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign b_mag = b_eff[31] ? (~b_eff + 32'd1) : b_eff;
  assign trial = {r_r[31:0], q_r[31]} - {1'b0, d_r};
  assign done  = busy_r && n_r == 6'd0;
  assign quot  = nq_r ? (~q_r + 32'd1) : q_r;
  assign rem   = nr_r ? (~r_r[31:0] + 32'd1) : r_r[31:0];

  // restoring division loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      n_r    <= 6'd32;
      q_r    <= a_mag;
      d_r    <= b_mag;
      r_r    <= 33'd0;
      nq_r   <= dividend[31] ^ b_eff[31];
      nr_r   <= dividend[31];
    end else if (busy_r) begin
      if (n_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        n_r <= n_r - 6'd1;
        if (!trial[32]) begin
          r_r <= trial;
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          r_r <= {r_r[31:0], q_r[31]};
          q_r <= {q_r[30:0], 1'b0};
        end
      end
    end
  end
endmodule

### sv/pbe_back.sv
// back end: operand stack, alu and result register
module pbe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pbe_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_value,
  output logic [2:0]    out_status
);
  import pbe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [31:0] mem [StackDepth];
  logic [31:0] top_r, sec_r;
  logic [CntW-1:0] cnt_r;
  logic [2:0]  err_r;
  logic [1:0]  st_r;
  logic [5:0]  op_r;
  logic        wr_en;
  logic [SpW-1:0] wr_addr;
  logic [31:0] wr_data, res;
  logic        div_start, div_done;
  logic [31:0] quot, rem;
  logic [63:0] prod;
  logic        binop, need;
  logic        slt, eqv;
  logic [CntW-1:0] depth_c;

  assign depth_c = CntW'(StackDepth);
  assign binop = cmd.op <= OP_MOD;
  assign need  = binop ? (cnt_r < CntW'(2)) : (cnt_r < CntW'(1));
  assign cmd_ready = st_r == S_IDLE && !(cmd.kind == K_END && out_valid);
  assign slt  = $signed(sec_r) < $signed(top_r);
  assign eqv  = sec_r == top_r;
  assign prod = sec_r * top_r;

  pbe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(sec_r), .divisor(top_r),
    .done(div_done), .quot(quot), .rem(rem)
  );

  // alu for all operators; divide and modulo take the divider outputs
  always_comb begin
    unique case (op_r)
      OP_LOR:  res = {31'd0, sec_r != 0 || top_r != 0};
      OP_LAND: res = {31'd0, sec_r != 0 && top_r != 0};
      OP_LE:   res = {31'd0, slt || eqv};
      OP_LT:   res = {31'd0, slt};
      OP_GE:   res = {31'd0, !slt};
      OP_GT:   res = {31'd0, !slt && !eqv};
      OP_EQ:   res = {31'd0, eqv};
      OP_NE:   res = {31'd0, !eqv};
      OP_XOR:  res = sec_r ^ top_r;
      OP_OR:   res = sec_r | top_r;
      OP_AND:  res = sec_r & top_r;
      OP_ADD:  res = sec_r + top_r;
      OP_SUB:  res = sec_r - top_r;
      OP_MUL:  res = prod[31:0];
      OP_DIV:  res = quot;
      OP_MOD:  res = rem;
      OP_NEG:  res = ~top_r + 32'd1;
      OP_LNOT: res = {31'd0, top_r == 0};
      default: res = ~top_r;
    endcase
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end
  // operands are captured while idle and held through execution
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE) begin
      top_r <= mem[SpW'(cnt_r - CntW'(1))];
      sec_r <= mem[SpW'(cnt_r - CntW'(2))];
    end
  end

  // sequencer
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = SpW'(cnt_r);
    wr_data   = cmd.data;
    div_start = 1'b0;
    if (st_r == S_IDLE && cmd_valid && cmd_ready && cmd.kind == K_PUSH &&
        err_r == ST_OK && cnt_r < depth_c) begin
      wr_en = 1'b1;
    end else if ((st_r == S_EXE && op_r != OP_DIV && op_r != OP_MOD) ||
                 (st_r == S_DIV && div_done)) begin
      wr_en   = 1'b1;
      wr_addr = SpW'(cnt_r - CntW'(1));
      wr_data = res;
    end
    if (st_r == S_EXE && (op_r == OP_DIV || op_r == OP_MOD)) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      err_r     <= ST_OK;
      out_valid <= 1'b0;
      op_r      <= OP_BAD;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          priority case (cmd.kind)
            K_PUSH: if (err_r == ST_OK) begin
              if (cnt_r < depth_c) cnt_r <= cnt_r + CntW'(1);
              else err_r <= ST_OVERFLOW;
            end
            K_END: begin
              st_r <= S_RD;
              op_r <= OP_BAD;
            end
            default: if (err_r == ST_OK) begin
              if (cmd.op == OP_BAD) err_r <= ST_UNKNOWN;
              else if (need) err_r <= ST_EMPTY;
              else begin
                op_r <= cmd.op;
                st_r <= S_RD;
                if (binop) cnt_r <= cnt_r - CntW'(1);
              end
            end
          endcase
        end
        S_RD: begin
          if (op_r == OP_BAD) begin
            // end of expression: top_r holds stack bottom when count is one
            out_valid  <= 1'b1;
            out_status <= (err_r != ST_OK) ? err_r :
                          (cnt_r == '0) ? ST_EMPTY :
                          (cnt_r > CntW'(1)) ? ST_MANY : ST_OK;
            out_value  <= (err_r == ST_OK && cnt_r == CntW'(1)) ? top_r : 32'd0;
            cnt_r <= '0;
            err_r <= ST_OK;
            st_r  <= S_IDLE;
          end else begin
            st_r <= S_EXE;
          end
        end
        S_EXE: st_r <= (op_r == OP_DIV || op_r == OP_MOD) ? S_DIV : S_IDLE;
        default: if (div_done) st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb.sv
// testbench for the postfix bytecode evaluator
`timescale 1ns / 1ps

module tb;
  import pbe_pkg::*;

  localparam int Depth = 32;
  localparam int IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_code_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_value;
  logic [2:0]  out_status;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } verdict_t;

  // evaluator mirror state
  logic [31:0] eval_stack [Depth];
  int          eval_count;
  logic [31:0] lit_accum;
  int          lit_shift;
  logic [2:0]  eval_err;

  verdict_t    verdict_q[$];
  int          mismatches;
  int          results_seen;
  int          bytes_sent;
  int          idle_cycles;
  bit          recv_long_stall;

  postfix_bytecode_evaluator u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_error(logic [2:0] e);
    if (eval_err == ST_OK) eval_err = e;
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (eval_err != ST_OK) return;
    if (eval_count >= Depth) begin
      flag_error(ST_OVERFLOW);
      return;
    end
    eval_stack[eval_count] = v;
    eval_count++;
  endfunction

  function automatic logic [31:0] apply_binary(logic [5:0] op, logic [31:0] a,
                                                logic [31:0] b);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [31:0] d;
    sa = a;
    sb = b;
    d = (sb == 0) ? 32'sd1 : sb;
    case (op)
      OP_LOR:  return {31'd0, (a != 0) || (b != 0)};
      OP_LAND: return {31'd0, (a != 0) && (b != 0)};
      OP_LE:   return {31'd0, sa <= sb};
      OP_LT:   return {31'd0, sa < sb};
      OP_GE:   return {31'd0, sa >= sb};
      OP_GT:   return {31'd0, sa > sb};
      OP_EQ:   return {31'd0, a == b};
      OP_NE:   return {31'd0, a != b};
      OP_XOR:  return a ^ b;
      OP_OR:   return a | b;
      OP_AND:  return a & b;
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      OP_DIV: begin
        // most negative over minus one wraps
        if (sa == 32'sh80000000 && d == -32'sd1) return 32'h80000000;
        return sa / d;
      end
      default: begin
        if (d == -32'sd1) return 32'd0;
        return sa % d;
      end
    endcase
  endfunction

  function automatic void apply_opcode(logic [5:0] op);
    logic [31:0] v;
    if (eval_err != ST_OK) return;
    if (op >= OP_LOR && op <= OP_MOD) begin
      if (eval_count < 2) begin
        flag_error(ST_EMPTY);
        return;
      end
      eval_count--;
      eval_stack[eval_count-1] = apply_binary(op, eval_stack[eval_count-1],
                                              eval_stack[eval_count]);
    end else if (op >= OP_NEG && op <= OP_NOT) begin
      if (eval_count < 1) begin
        flag_error(ST_EMPTY);
        return;
      end
      v = eval_stack[eval_count-1];
      if (op == OP_NEG) v = -v;
      else if (op == OP_LNOT) v = (v == 0) ? 32'd1 : 32'd0;
      else v = ~v;
      eval_stack[eval_count-1] = v;
    end else begin
      flag_error(ST_UNKNOWN);
    end
  endfunction

  function automatic void add_literal_part(logic [7:0] b);
    if (lit_shift < 32) lit_accum += {25'd0, b[6:0]} << lit_shift;
  endfunction

  // advance the mirror by one byte, queue a verdict on end of expression
  function automatic void predict_byte(logic [7:0] b);
    verdict_t vd;
    if (b >= 8'hC0) begin
      add_literal_part(b);
      if (lit_shift < 32) lit_shift += 6;
    end else if (b >= 8'h80 || lit_shift != 0) begin
      add_literal_part(b);
      push_operand(lit_accum);
      lit_accum = 0;
      lit_shift = 0;
    end else if (b != 8'd0) begin
      apply_opcode(b[5:0] | (b[6] ? OP_BAD : 6'd0));
    end else begin
      vd.status = eval_err;
      vd.value = 32'd0;
      if (eval_err == ST_OK) begin
        if (eval_count == 0) vd.status = ST_EMPTY;
        else if (eval_count > 1) vd.status = ST_MANY;
        else vd.value = eval_stack[0];
      end
      verdict_q.push_back(vd);
      eval_count = 0;
      lit_accum = 0;
      lit_shift = 0;
      eval_err = ST_OK;
    end
  endfunction

  // random gap: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one byte and update the prediction on acceptance
  task automatic send_byte(logic [7:0] b, bit gaps = 1);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  // encode a value as a literal: continuation parts low first, then a closing part
  task automatic send_literal(logic [31:0] v);
    logic [31:0] rest;
    rest = v;
    while (rest > 32'd63) begin
      send_byte(8'hC0 | {2'b00, rest[5:0]});
      rest = rest >> 6;
    end
    send_byte(8'h80 | {2'b00, rest[5:0]});
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'hFFFFFFFF;
      2: return $urandom_range(0, 3);
      3: return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  // result checker, with random receiver stalls
  always @(posedge clk) begin
    verdict_t vd;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h status=%0d",
                                       out_value, out_status);
      end else begin
        vd = verdict_q.pop_front();
        if (out_value !== vd.value || out_status !== vd.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     vd.value, vd.status, out_value, out_status);
        end
      end
    end
    if (!rst_n) out_ready <= 1'b0;
    else if (recv_long_stall) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 60);
  end

  // occasionally hold the receiver off for a long stretch
  initial begin
    recv_long_stall = 1'b0;
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk);
      recv_long_stall <= 1'b1;
      repeat ($urandom_range(20, 60)) @(posedge clk);
      recv_long_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_literals();
    send_literal(32'd0);
    send_byte(8'd0);
    send_literal(32'hFFFFFFFF);
    send_byte(8'd0);
    send_literal(32'h80000000);
    send_byte(8'd0);
    // long literal with parts past bit 32, closed by a zero byte
    repeat (8) send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'd0);
    // literal closed by an opcode-range byte
    send_byte(8'hC5);
    send_byte(8'h7F);
    send_byte(8'd0);
  endtask

  task automatic test_operators();
    for (int op = OP_LOR; op <= OP_MOD; op++) begin
      send_literal(rand_operand());
      send_literal(op >= OP_DIV ? 32'd0 : rand_operand());
      send_byte(op[7:0]);
      send_byte(8'd0);
    end
    send_literal(32'h80000000);
    send_literal(32'hFFFFFFFF);
    send_byte({2'b00, OP_DIV});
    send_byte(8'd0);
    for (int op = OP_NEG; op <= OP_NOT; op++) begin
      send_literal(rand_operand());
      send_byte(op[7:0]);
      send_byte(8'd0);
    end
  endtask

  task automatic test_errors();
    send_byte(8'd0);
    send_literal(32'd1);
    send_literal(32'd2);
    send_byte(8'd0);
    send_byte({2'b00, OP_ADD});
    send_literal(32'd5);
    send_byte(8'd0);
    send_byte(8'd3);
    send_byte(8'd0);
    send_byte(8'h40);
    send_byte(8'd0);
    repeat (Depth + 1) send_byte(8'h81);
    send_byte(8'd0);
  endtask

  // random expressions that never underflow the stack, plus noise
  task automatic test_random();
    int depth;
    int n;
    while (bytes_sent < 1050) begin
      if ($urandom_range(0, 9) < 8) begin
        depth = 0;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          if (depth < 2 || ($urandom_range(0, 1) && depth < Depth)) begin
            send_literal(rand_operand());
            depth++;
          end else if ($urandom_range(0, 3) == 0) begin
            send_byte(8'($urandom_range(OP_NEG, OP_NOT)));
          end else begin
            // divides are slow, keep them rarer
            send_byte($urandom_range(0, 4) == 0 ? 8'($urandom_range(OP_DIV, OP_MOD))
                                               : 8'($urandom_range(OP_LOR, OP_MUL)));
            depth--;
          end
        end
        while (depth > 1 && $urandom_range(0, 3) != 0) begin
          send_byte(8'($urandom_range(OP_LOR, OP_MUL)));
          depth--;
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(8'd0);
      if ($urandom_range(0, 30) == 0) drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_code_byte = 8'd0;
    out_ready = 1'b0;
    eval_count = 0;
    lit_accum = 0;
    lit_shift = 0;
    eval_err = ST_OK;
    mismatches = 0;
    results_seen = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals();
    test_operators();
    test_errors();
    drain_results();
    test_random();
    drain_results();
    $display("covered %0d code bytes and %0d expression results", bytes_sent, results_seen);
    $display("literals, all operators, errors, overflow and random expressions");
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### postfix_bytecode_evaluator.f
+incdir+sv
sv/pbe_pkg.sv
sv/pbe_front.sv
sv/pbe_queue.sv
sv/pbe_div.sv
sv/pbe_back.sv
sv/postfix_bytecode_evaluator.sv
tb/tb.sv
